### rtl/sorted_color_palette_builder_macros.svh
// Assertion macros shared by the palette builder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SORTED_COLOR_PALETTE_BUILDER_MACROS_SVH
`define SORTED_COLOR_PALETTE_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCPB_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCPB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/scpb_pkg.sv
// Shared types and codes for the sorted color palette builder.
// Used by the cell module and the top level; depends on nothing.
`default_nettype none

package scpb_pkg;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_READ   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] pixel_color;
		logic [7:0]  entry_index;
	} item_t;

	typedef struct packed {
		logic [31:0] entry_color;
		logic        entry_valid;
		logic [8:0]  entry_count;
		logic        overflowed;
	} result_t;

	typedef struct packed {
		logic cmp_en;
		logic upd_en;
		logic rd_en;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/sorted_color_palette_builder.sv
// Sorted color palette builder: a row of MAX_COLORS cells keeps distinct RGBA colors in
// ascending order. An insert is captured, compared in every cell, then shifted and
// updated; a clear or an unused code skips the compare; a read of an index below the
// count walks the entry one cell per cycle down the readout chain to cell zero. One
// item is in flight at a time, and a finished result may wait in the output
// register while the next item is accepted. Depends on scpb_pkg, scpb_cell and
// sorted_color_palette_builder_macros.svh.
`default_nettype none

module sorted_color_palette_builder #(
	parameter int MAX_COLORS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  scpb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output scpb_pkg::result_t result
);
	import scpb_pkg::*;
	`include "sorted_color_palette_builder_macros.svh"

	localparam int CNT_W = $clog2(MAX_COLORS + 1);
	localparam int CW    = (CNT_W > 8) ? CNT_W : 8;
	localparam int OW    = (CNT_W > 9) ? CNT_W : 9;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       func_q;
	logic [31:0]      color_q;
	logic [7:0]       idx_q;
	logic [7:0]       rd_cnt_q;
	logic             hit_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             out_valid_q;
	result_t          out_q;

	logic [CW-1:0]    cnt_cw;
	logic             accept;
	logic             fin_go;
	logic             dup;
	logic             full;
	logic             do_ins;
	logic             is_read;
	logic [CNT_W-1:0] count_nxt;
	logic             ovf_nxt;
	logic [OW-1:0]    count_ow;
	cell_ctrl_t       ctrl;

	logic [31:0] entry_w [MAX_COLORS];
	logic [31:0] bus_w   [MAX_COLORS];
	logic [MAX_COLORS-1:0] lt_w;
	logic [MAX_COLORS-1:0] eq_w;
	logic [MAX_COLORS-1:0] live_w;
	logic [MAX_COLORS-1:0] sel_w;

	assign cnt_cw     = CW'(count_q);
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign fin_go     = (state_q == ST_FIN) && (!out_valid_q || result_ready);
	assign dup        = |eq_w;
	assign full       = (count_q == CNT_W'(MAX_COLORS));
	assign do_ins     = fin_go && (func_q == FUNC_INSERT) && !dup && !full;
	assign is_read    = (func_q == FUNC_READ) && hit_q;

	assign ctrl.cmp_en = (state_q == ST_CMP);
	assign ctrl.upd_en = do_ins;
	assign ctrl.rd_en  = (state_q == ST_RD);

	always_comb begin
		count_nxt = count_q;
		ovf_nxt   = ovf_q;
		case (func_q)
			FUNC_INSERT: begin
				if (!dup && full) begin
					ovf_nxt = 1'b1;
				end else if (!dup) begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			FUNC_CLEAR: begin
				count_nxt = '0;
				ovf_nxt   = 1'b0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	assign count_ow = OW'(count_nxt);

	for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
		assign live_w[i] = (CW'(i) < cnt_cw);
		assign sel_w[i]  = (CW'(i) == CW'(idx_q));

		scpb_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.color    (color_q),
			.shift_in ((i == 0) ? color_q : entry_w[(i == 0) ? 0 : i - 1]),
			.bus_in   ((i == MAX_COLORS - 1) ? 32'd0
			           : bus_w[(i == MAX_COLORS - 1) ? i : i + 1]),
			.prev_lt  ((i == 0) ? 1'b1 : lt_w[(i == 0) ? 0 : i - 1]),
			.live     (live_w[i]),
			.rd_sel   (sel_w[i]),
			.entry    (entry_w[i]),
			.bus_out  (bus_w[i]),
			.lt       (lt_w[i]),
			.eq       (eq_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			rd_cnt_q    <= '0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
				count_q     <= count_nxt;
				ovf_q       <= ovf_nxt;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.func)
							FUNC_INSERT: state_q <= ST_CMP;
							FUNC_READ: begin
								state_q  <= (CW'(item.entry_index) < cnt_cw) ? ST_RD : ST_FIN;
								rd_cnt_q <= item.entry_index;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_CMP: state_q <= ST_FIN;
				ST_RD: begin
					if (rd_cnt_q == 8'd0) begin
						state_q <= ST_FIN;
					end else begin
						rd_cnt_q <= rd_cnt_q - 8'd1;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= item.func;
			color_q <= item.pixel_color;
			idx_q   <= item.entry_index;
			hit_q   <= (CW'(item.entry_index) < cnt_cw);
		end
		if (fin_go) begin
			out_q.entry_color <= is_read ? bus_w[0] : 32'd0;
			out_q.entry_valid <= is_read;
			out_q.entry_count <= count_ow[8:0];
			out_q.overflowed  <= ovf_nxt;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`SCPB_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_COLORS),
		"Palette count exceeds the table size.")
	`SCPB_ASSERT_NEXT(a_insert_compares, clk, arst_n, accept && item.func == FUNC_INSERT,
		state_q == ST_CMP, "Insert transfer did not enter the compare cycle.")
	`SCPB_ASSERT_NEXT(a_full_sets_ovf, clk, arst_n,
		fin_go && func_q == FUNC_INSERT && !dup && full,
		ovf_q && $stable(count_q), "Dropped color did not set the overflow flag.")
	`SCPB_ASSERT_NEXT(a_clear_empties, clk, arst_n, fin_go && func_q == FUNC_CLEAR,
		count_q == '0 && !ovf_q, "Clear did not empty the palette.")
	`SCPB_ASSERT_NOW(a_read_hit_live, clk, arst_n, state_q == ST_RD,
		hit_q && func_q == FUNC_READ, "Readout chain running without a valid read.")

endmodule

`default_nettype wire

### rtl/scpb_cell.sv
// One palette cell: holds one sorted entry, compares it against the insert
// color, shifts from its lower neighbor and forwards the readout chain. Uses scpb_pkg.
`default_nettype none

module scpb_cell (
	input  logic              clk,
	input  scpb_pkg::cell_ctrl_t ctrl,
	input  logic [31:0]       color,
	input  logic [31:0]       shift_in,
	input  logic [31:0]       bus_in,
	input  logic              prev_lt,
	input  logic              live,
	input  logic              rd_sel,
	output logic [31:0]       entry,
	output logic [31:0]       bus_out,
	output logic              lt,
	output logic              eq
);
	import scpb_pkg::*;

	logic [31:0] entry_q;
	logic [31:0] bus_q;
	logic        lt_q;
	logic        eq_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_q <= live && (entry_q < color);
			eq_q <= live && (entry_q == color);
		end
		if (ctrl.upd_en && !lt_q) begin
			entry_q <= prev_lt ? color : shift_in;
		end
		if (ctrl.rd_en) begin
			bus_q <= rd_sel ? entry_q : bus_in;
		end
	end

	assign entry   = entry_q;
	assign bus_out = bus_q;
	assign lt      = lt_q;
	assign eq      = eq_q;

endmodule

`default_nettype wire

### sim/tb_sorted_color_palette_builder.sv
// Testbench for the sorted color palette builder: directed and random images are driven
// as valid/ready transfers and every result is checked against a palette predictor.
// Depends on scpb_pkg and the sorted_color_palette_builder RTL.
`default_nettype none

module tb_sorted_color_palette_builder;
	timeunit 1ns;
	timeprecision 1ps;

	import scpb_pkg::*;

	localparam int MAX_COLORS = 256;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_START = 400;
	localparam int HOLD_LEN = 300;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;

	class palette_scoreboard;
		logic [31:0] entries [MAX_COLORS];
		int unsigned count;
		bit ovf;
		result_t answer_q[$];
		int mismatches;

		function void report(string msg);
			if (mismatches < 10)
				$display("%0t: %s", $realtime, msg);
			mismatches++;
		endfunction

		function void record_item(item_t it);
			result_t r;
			int unsigned pos;
			r = '0;
			case (it.func)
				FUNC_INSERT: begin
					pos = 0;
					while (pos < count && entries[pos] < it.pixel_color)
						pos++;
					if (!(pos < count && entries[pos] == it.pixel_color)) begin
						if (count >= MAX_COLORS) begin
							ovf = 1'b1;
						end else begin
							for (int unsigned i = count; i > pos; i--)
								entries[i] = entries[i - 1];
							entries[pos] = it.pixel_color;
							count++;
						end
					end
				end
				FUNC_READ: begin
					if (it.entry_index < count) begin
						r.entry_color = entries[it.entry_index];
						r.entry_valid = 1'b1;
					end
				end
				FUNC_CLEAR: begin
					count = 0;
					ovf = 1'b0;
				end
				default: ;
			endcase
			r.entry_count = 9'(count);
			r.overflowed = ovf;
			answer_q.push_back(r);
		endfunction

		function void check_answer(result_t got);
			result_t exp;
			if (answer_q.size() == 0) begin
				report($sformatf("result with nothing expected: color %h valid %b count %0d ovf %b",
					got.entry_color, got.entry_valid, got.entry_count, got.overflowed));
				return;
			end
			exp = answer_q.pop_front();
			if (got.entry_color !== exp.entry_color || got.entry_valid !== exp.entry_valid ||
				got.entry_count !== exp.entry_count || got.overflowed !== exp.overflowed)
				report($sformatf("mismatch: expected color %h valid %b count %0d ovf %b, got color %h valid %b count %0d ovf %b",
					exp.entry_color, exp.entry_valid, exp.entry_count, exp.overflowed,
					got.entry_color, got.entry_valid, got.entry_count, got.overflowed));
		endfunction

		function int pending();
			return answer_q.size();
		endfunction

		function void close_out();
			while (answer_q.size() != 0) begin
				void'(answer_q.pop_front());
				report("expected result never arrived");
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic result_valid;
	logic result_ready;
	result_t result;

	palette_scoreboard sb = new;
	int burst_left = 0;
	int random_sent = 0;

	sorted_color_palette_builder #(
		.MAX_COLORS(MAX_COLORS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				sb.record_item(item);
			if (result_valid && result_ready)
				sb.check_answer(result);
		end
	end

	initial begin
		int idle;
		idle = 0;
		do begin
			@(posedge clk);
			if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
				idle = 0;
			else
				idle++;
		end while (idle < IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int cyc;
		cyc = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
				result_ready <= 1'b0;
			end else begin
				case ((cyc / 50) % 4)
					0: result_ready <= 1'b1;
					1: result_ready <= 1'($urandom_range(0, 1));
					2: result_ready <= (cyc % 5) != 0;
					default: result_ready <= $urandom_range(0, 7) == 0;
				endcase
			end
		end
	end

	task automatic send_op(input logic [1:0] func, input logic [31:0] color,
		input logic [7:0] index);
		item_t it;
		int gap;
		it.func = func;
		it.pixel_color = color;
		it.entry_index = index;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic send_image(input bit overfill);
		logic [31:0] pool [64];
		int pool_n;
		int inserts;
		int reads;
		int style;
		logic [31:0] base;
		if (overfill || $urandom_range(0, 7) != 0) begin
			send_op(FUNC_CLEAR, $urandom, 8'($urandom));
			random_sent++;
		end
		if (overfill) begin
			pool_n = 0;
			for (int i = 0; i < MAX_COLORS + 10; i++) begin
				base = $urandom;
				if (i < 8)
					pool[i] = base;
				send_op(FUNC_INSERT, base, 8'($urandom));
				random_sent++;
			end
			for (int i = 0; i < 8; i++) begin
				send_op(FUNC_INSERT, pool[$urandom_range(0, 7)], 8'($urandom));
				random_sent++;
			end
			send_op(FUNC_READ, $urandom, 8'd0);
			send_op(FUNC_READ, $urandom, 8'd255);
			send_op(FUNC_READ, $urandom, 8'd128);
			send_op(FUNC_READ, $urandom, 8'($urandom_range(192, 255)));
			random_sent += 4;
			return;
		end
		pool_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
		style = $urandom_range(0, 3);
		base = $urandom;
		for (int i = 0; i < pool_n; i++) begin
			case (style)
				0: pool[i] = {base[31:8], 8'($urandom)};
				1: pool[i] = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0000_0000;
				default: pool[i] = $urandom;
			endcase
		end
		inserts = $urandom_range(1, 40);
		for (int i = 0; i < inserts; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				send_op(($urandom_range(0, 1) != 0) ? FUNC_UNUSED : 2'($urandom),
					$urandom, 8'($urandom));
				random_sent++;
			end
			send_op(FUNC_INSERT, pool[$urandom_range(0, pool_n - 1)], 8'($urandom));
			random_sent++;
		end
		reads = $urandom_range(1, 6);
		for (int i = 0; i < reads; i++) begin
			send_op(FUNC_READ, $urandom, ($urandom_range(0, 9) == 0) ?
				8'($urandom) : 8'($urandom_range(0, pool_n - 1)));
			random_sent++;
		end
	endtask

	initial begin
		int img;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_op(FUNC_CLEAR, 32'h0, 8'h0);
		send_op(FUNC_READ, 32'h0, 8'd0);
		send_op(FUNC_READ, 32'hffff_ffff, 8'd255);
		send_op(FUNC_INSERT, 32'h8000_0000, 8'h0);
		send_op(FUNC_INSERT, 32'h0000_0000, 8'hff);
		send_op(FUNC_INSERT, 32'hffff_ffff, 8'h0);
		send_op(FUNC_INSERT, 32'h8000_0000, 8'h0);
		send_op(FUNC_INSERT, 32'h7fff_ffff, 8'h0);
		send_op(FUNC_INSERT, 32'h0000_0001, 8'h0);
		for (int i = 0; i < 5; i++)
			send_op(FUNC_READ, 32'h0, 8'(i));
		send_op(FUNC_READ, 32'h0, 8'd5);
		send_op(FUNC_READ, 32'h0, 8'd255);
		send_op(FUNC_UNUSED, 32'hffff_ffff, 8'hff);
		send_op(FUNC_INSERT, 32'h0000_0000, 8'h0);
		send_op(FUNC_CLEAR, 32'hffff_ffff, 8'hff);
		send_op(FUNC_READ, 32'h0, 8'd0);
		send_op(FUNC_INSERT, 32'haaaa_5555, 8'h0);
		send_op(FUNC_READ, 32'h0, 8'd0);

		img = 0;
		while (random_sent < RANDOM_ITEMS) begin
			send_image(img == 1);
			img++;
		end
		send_op(FUNC_READ, 32'h0, 8'd0);

		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/scpb_pkg.sv
rtl/scpb_cell.sv
rtl/sorted_color_palette_builder.sv
sim/tb_sorted_color_palette_builder.sv
